@@ design/spq_pkg.sv @@
// Package for the sorted priority queue: capacity, request and status codes,
// and the per-cell control code. No dependencies.
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int PRIO_W   = 16;
    localparam int VAL_W    = 32;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_DEQUEUE = 2'd1,
        REQ_PEEK    = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // What a cell loads at the next edge.
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LEFT  = 2'd2,
        CELL_FROM_RIGHT = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [PRIO_W-1:0] new_prio;
        logic [VAL_W-1:0]  new_value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/sorted_priority_queue_top.sv @@
// Top level of the sorted priority queue: a row of spq_cell slots kept in
// ascending priority order, the occupancy counter and the result register.
// Depends on spq_pkg and spq_cell.
//
//  channel   handshake               fields
//  request   start && !busy          req_type, priority_req, value
//  result    done (one cycle)        result_value, status, entry_count
//
// One request per cycle; busy stays low. The result of a request accepted at
// one edge is shown with done during the following cycle. Every slot decides
// in parallel from its own compare against the request priority and its left
// neighbor's decision, so an insert or dequeue shifts the whole row at the
// edge that accepts it. Reset clears only the occupancy count and done;
// slot contents are left as they are. The receiver cannot stall.
`default_nettype none

module sorted_priority_queue_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                req_type,
    input  wire logic signed [15:0]        priority_req,
    input  wire logic signed [31:0]        value,
    output logic                           done,
    output logic signed [31:0]             result_value,
    output logic      [1:0]                status,
    output logic      [6:0]                entry_count
);
    import spq_pkg::*;

    logic [PRIO_W-1:0] prio_w  [CAPACITY];
    logic [VAL_W-1:0]  value_w [CAPACITY];
    logic [CAPACITY-1:0] le_w;
    logic [CAPACITY-1:0] after_w;
    cell_ctrl_t          ctrl_w [CAPACITY];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             done_next;
    logic [VAL_W-1:0] result_reg;
    logic [VAL_W-1:0] result_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;

    logic  accept;
    req_t  req;
    logic  empty;
    logic  full;
    logic  do_insert;
    logic  do_dequeue;
    logic  front;

    assign busy       = 1'b0;
    assign accept     = start && !busy;
    assign req        = req_t'(req_type);
    assign empty      = (count_reg == '0);
    assign full       = (count_reg >= CNT_W'(CAPACITY));
    assign do_insert  = accept && (req == REQ_INSERT) && !full;
    assign do_dequeue = accept && (req == REQ_DEQUEUE) && !empty;
    // only a strictly lower priority, or an empty queue, takes the front slot
    assign front      = empty || (le_w[0] && (priority_req != prio_w[0]));

    // after_w[i]: slot i lies at or beyond the insert point.
    assign after_w[0] = front;

    for (genvar i = 1; i < CAPACITY; i++)
    begin : g_after
        assign after_w[i] = front || (count_reg <= CNT_W'(i)) || le_w[i];
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [PRIO_W-1:0] left_prio;
        logic [VAL_W-1:0]  left_value;
        logic [PRIO_W-1:0] right_prio;
        logic [VAL_W-1:0]  right_value;
        cell_op_t          op;

        if (i == 0)
        begin : g_first
            assign left_prio  = priority_req;
            assign left_value = value;
        end
        else
        begin : g_mid
            assign left_prio  = prio_w[i-1];
            assign left_value = value_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_prio  = '0;
            assign right_value = '0;
        end
        else
        begin : g_inner
            assign right_prio  = prio_w[i+1];
            assign right_value = value_w[i+1];
        end

        always_comb
        begin
            op = CELL_HOLD;
            if (do_insert)
            begin
                if (i > 0 && after_w[(i > 0) ? i - 1 : 0])
                    op = CELL_FROM_LEFT;
                else if (after_w[i])
                    op = CELL_LOAD;
            end
            else if (do_dequeue)
            begin
                op = CELL_FROM_RIGHT;
            end
        end

        assign ctrl_w[i] = '{op: op, new_prio: priority_req, new_value: value};

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl_w[i]),
            .left_prio   (left_prio),
            .left_value  (left_value),
            .right_prio  (right_prio),
            .right_value (right_value),
            .prio        (prio_w[i]),
            .value       (value_w[i]),
            .new_le      (le_w[i])
        );
    end

    always_comb
    begin
        count_next  = count_reg;
        done_next   = accept;
        result_next = '0;
        status_next = ST_OK;
        if (accept)
        begin
            case (req)
                REQ_INSERT:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                REQ_DEQUEUE, REQ_PEEK:
                begin
                    if (empty)
                    begin
                        result_next = '1;
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        result_next = value_w[0];
                        if (req == REQ_DEQUEUE)
                            count_next = count_reg - CNT_W'(1);
                    end
                end
                REQ_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        status_reg <= status_next;
    end

    // count is reported after the request, so it comes from the register
    assign done         = done_reg;
    assign result_value = result_reg;
    assign status       = status_reg;
    assign entry_count  = count_reg;

endmodule

`default_nettype wire

@@ design/spq_cell.sv @@
// One slot of the sorted queue: holds a priority and a value, compares the
// incoming priority with its own, and loads from the request or a neighbor.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
    input  wire logic                      clk,
    input  wire spq_pkg::cell_ctrl_t       ctrl,
    input  wire logic [spq_pkg::PRIO_W-1:0] left_prio,
    input  wire logic [spq_pkg::VAL_W-1:0]  left_value,
    input  wire logic [spq_pkg::PRIO_W-1:0] right_prio,
    input  wire logic [spq_pkg::VAL_W-1:0]  right_value,
    output logic      [spq_pkg::PRIO_W-1:0] prio,
    output logic      [spq_pkg::VAL_W-1:0]  value,
    output logic                            new_le
);
    import spq_pkg::*;

    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;
    logic [VAL_W-1:0]  value_reg;
    logic [VAL_W-1:0]  value_next;

    always_comb
    begin
        prio_next  = prio_reg;
        value_next = value_reg;
        case (ctrl.op)
            CELL_HOLD:
            begin
                prio_next  = prio_reg;
                value_next = value_reg;
            end
            CELL_LOAD:
            begin
                prio_next  = ctrl.new_prio;
                value_next = ctrl.new_value;
            end
            CELL_FROM_LEFT:
            begin
                prio_next  = left_prio;
                value_next = left_value;
            end
            CELL_FROM_RIGHT:
            begin
                prio_next  = right_prio;
                value_next = right_value;
            end
            default:
            begin
                prio_next  = prio_reg;
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prio_reg  <= prio_next;
        value_reg <= value_next;
    end

    assign prio   = prio_reg;
    assign value  = value_reg;
    assign new_le = $signed(ctrl.new_prio) <= $signed(prio_reg);

endmodule

`default_nettype wire
